FILE: rtl/qvr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qvr_pkg: shared types and arithmetic for the quaternion vector rotator
// Holds the data width, the derived widths of every pipeline stage, the
// stage load-enable bundle and the rounding and saturation functions.
// ----------------------------------------------------------------------------
package qvr_pkg;

	// Width of every vector and quaternion component; signed fixed point
	// with two integer bits (Q1.14 at 16 bits).
	localparam int DATA_WIDTH = 16;
	localparam int FRAC       = DATA_WIDTH - 2;

	// First Hamilton product q * (0, v): three products per component.
	localparam int PROD1_W = 2 * DATA_WIDTH;
	localparam int ACC1_W  = PROD1_W + 2;
	localparam int T_W     = ACC1_W - FRAC;

	// Second Hamilton product t * conj(q): four products per component.
	localparam int PROD2_W = T_W + DATA_WIDTH;
	localparam int ACC2_W  = PROD2_W + 2;

	// Stream payload widths, rounded up to whole bytes.
	localparam int IN_FIELDS   = 7;
	localparam int OUT_FIELDS  = 3;
	localparam int IN_TDATA_W  = ((IN_FIELDS * DATA_WIDTH + 7) / 8) * 8;
	localparam int OUT_TDATA_W = ((OUT_FIELDS * DATA_WIDTH + 7) / 8) * 8;

	typedef logic signed [DATA_WIDTH-1:0] data_t;
	typedef logic signed [PROD1_W-1:0]    prod1_t;
	typedef logic signed [ACC1_W-1:0]     acc1_t;
	typedef logic signed [T_W-1:0]        tq_t;
	typedef logic signed [PROD2_W-1:0]    prod2_t;
	typedef logic signed [ACC2_W-1:0]     acc2_t;

	// Load enables of the four pipeline stages.
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
	} stage_en_t;

	// Round to nearest, ties toward plus infinity, then drop FRAC bits.
	// The result keeps full width, so no saturation is needed.
	function automatic tq_t round_t(input acc1_t acc);
		acc1_t biased;
		acc1_t shifted;
		begin
			biased  = acc + (acc1_t'(1) <<< (FRAC - 1));
			shifted = biased >>> FRAC;
			return shifted[T_W-1:0];
		end
	endfunction

	// Same rounding for the output sums, then clamp to the signed data range.
	function automatic data_t round_sat(input acc2_t acc);
		acc2_t                     biased;
		acc2_t                     shifted;
		logic [ACC2_W-DATA_WIDTH:0] upper;
		begin
			biased  = acc + (acc2_t'(1) <<< (FRAC - 1));
			shifted = biased >>> FRAC;
			upper   = shifted[ACC2_W-1:DATA_WIDTH-1];
			if ((&upper) || !(|upper)) begin
				return shifted[DATA_WIDTH-1:0];
			end else if (shifted[ACC2_W-1]) begin
				return {1'b1, {(DATA_WIDTH-1){1'b0}}};
			end else begin
				return {1'b0, {(DATA_WIDTH-1){1'b1}}};
			end
		end
	endfunction

endpackage

FILE: rtl/qvr_qv_product.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qvr_qv_product: Hamilton product of the quaternion and the vector
// Stage 1 registers the twelve nonzero partial products of q * (0, v);
// stage 2 sums and rounds them into the four components of t.
// ----------------------------------------------------------------------------
module qvr_qv_product (
	input  logic               clk,
	input  qvr_pkg::stage_en_t en,
	input  qvr_pkg::data_t     vec_x,
	input  qvr_pkg::data_t     vec_y,
	input  qvr_pkg::data_t     vec_z,
	input  qvr_pkg::data_t     quat_w,
	input  qvr_pkg::data_t     quat_i,
	input  qvr_pkg::data_t     quat_j,
	input  qvr_pkg::data_t     quat_k,
	output qvr_pkg::tq_t       t_w,
	output qvr_pkg::tq_t       t_x,
	output qvr_pkg::tq_t       t_y,
	output qvr_pkg::tq_t       t_z,
	output qvr_pkg::data_t     q_w,
	output qvr_pkg::data_t     q_i,
	output qvr_pkg::data_t     q_j,
	output qvr_pkg::data_t     q_k
);
	import qvr_pkg::*;

	prod1_t p_s1 [12];
	data_t  qw_s1, qi_s1, qj_s1, qk_s1;
	data_t  qw_s2, qi_s2, qj_s2, qk_s2;
	tq_t    tw_s2, tx_s2, ty_s2, tz_s2;
	acc1_t  sum_w, sum_x, sum_y, sum_z;

	// Stage 1: products, grouped three per component of t.
	always_ff @(posedge clk) begin
		if (en.s1) begin
			p_s1[0]  <= prod1_t'(quat_i) * prod1_t'(vec_x);
			p_s1[1]  <= prod1_t'(quat_j) * prod1_t'(vec_y);
			p_s1[2]  <= prod1_t'(quat_k) * prod1_t'(vec_z);
			p_s1[3]  <= prod1_t'(quat_w) * prod1_t'(vec_x);
			p_s1[4]  <= prod1_t'(quat_j) * prod1_t'(vec_z);
			p_s1[5]  <= prod1_t'(quat_k) * prod1_t'(vec_y);
			p_s1[6]  <= prod1_t'(quat_w) * prod1_t'(vec_y);
			p_s1[7]  <= prod1_t'(quat_i) * prod1_t'(vec_z);
			p_s1[8]  <= prod1_t'(quat_k) * prod1_t'(vec_x);
			p_s1[9]  <= prod1_t'(quat_w) * prod1_t'(vec_z);
			p_s1[10] <= prod1_t'(quat_i) * prod1_t'(vec_y);
			p_s1[11] <= prod1_t'(quat_j) * prod1_t'(vec_x);
			qw_s1    <= quat_w;
			qi_s1    <= quat_i;
			qj_s1    <= quat_j;
			qk_s1    <= quat_k;
		end
	end

	always_comb begin
		sum_w = -(acc1_t'(p_s1[0]) + acc1_t'(p_s1[1]) + acc1_t'(p_s1[2]));
		sum_x = acc1_t'(p_s1[3]) + acc1_t'(p_s1[4]) - acc1_t'(p_s1[5]);
		sum_y = acc1_t'(p_s1[6]) - acc1_t'(p_s1[7]) + acc1_t'(p_s1[8]);
		sum_z = acc1_t'(p_s1[9]) + acc1_t'(p_s1[10]) - acc1_t'(p_s1[11]);
	end

	// Stage 2: rounded components of t, quaternion carried alongside.
	always_ff @(posedge clk) begin
		if (en.s2) begin
			tw_s2 <= round_t(sum_w);
			tx_s2 <= round_t(sum_x);
			ty_s2 <= round_t(sum_y);
			tz_s2 <= round_t(sum_z);
			qw_s2 <= qw_s1;
			qi_s2 <= qi_s1;
			qj_s2 <= qj_s1;
			qk_s2 <= qk_s1;
		end
	end

	assign t_w = tw_s2;
	assign t_x = tx_s2;
	assign t_y = ty_s2;
	assign t_z = tz_s2;
	assign q_w = qw_s2;
	assign q_i = qi_s2;
	assign q_j = qj_s2;
	assign q_k = qk_s2;

endmodule

FILE: rtl/qvr_conj_product.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qvr_conj_product: product of t with the conjugate quaternion
// Stage 3 registers the twelve partial products of the vector part of
// t * conj(q); stage 4 sums, rounds and saturates them into the result.
// ----------------------------------------------------------------------------
module qvr_conj_product (
	input  logic               clk,
	input  qvr_pkg::stage_en_t en,
	input  qvr_pkg::tq_t       t_w,
	input  qvr_pkg::tq_t       t_x,
	input  qvr_pkg::tq_t       t_y,
	input  qvr_pkg::tq_t       t_z,
	input  qvr_pkg::data_t     q_w,
	input  qvr_pkg::data_t     q_i,
	input  qvr_pkg::data_t     q_j,
	input  qvr_pkg::data_t     q_k,
	output qvr_pkg::data_t     rot_x,
	output qvr_pkg::data_t     rot_y,
	output qvr_pkg::data_t     rot_z
);
	import qvr_pkg::*;

	prod2_t p_s3 [12];
	data_t  rx_s4, ry_s4, rz_s4;
	acc2_t  sum_x, sum_y, sum_z;

	// Stage 3: four products per output component; signs are applied in the sum.
	always_ff @(posedge clk) begin
		if (en.s3) begin
			p_s3[0]  <= prod2_t'(t_w) * prod2_t'(q_i);
			p_s3[1]  <= prod2_t'(t_x) * prod2_t'(q_w);
			p_s3[2]  <= prod2_t'(t_y) * prod2_t'(q_k);
			p_s3[3]  <= prod2_t'(t_z) * prod2_t'(q_j);
			p_s3[4]  <= prod2_t'(t_w) * prod2_t'(q_j);
			p_s3[5]  <= prod2_t'(t_x) * prod2_t'(q_k);
			p_s3[6]  <= prod2_t'(t_y) * prod2_t'(q_w);
			p_s3[7]  <= prod2_t'(t_z) * prod2_t'(q_i);
			p_s3[8]  <= prod2_t'(t_w) * prod2_t'(q_k);
			p_s3[9]  <= prod2_t'(t_x) * prod2_t'(q_j);
			p_s3[10] <= prod2_t'(t_y) * prod2_t'(q_i);
			p_s3[11] <= prod2_t'(t_z) * prod2_t'(q_w);
		end
	end

	always_comb begin
		sum_x = -acc2_t'(p_s3[0]) + acc2_t'(p_s3[1])
			- acc2_t'(p_s3[2]) + acc2_t'(p_s3[3]);
		sum_y = -acc2_t'(p_s3[4]) + acc2_t'(p_s3[5])
			+ acc2_t'(p_s3[6]) - acc2_t'(p_s3[7]);
		sum_z = -acc2_t'(p_s3[8]) - acc2_t'(p_s3[9])
			+ acc2_t'(p_s3[10]) + acc2_t'(p_s3[11]);
	end

	// Stage 4: the output register of the block.
	always_ff @(posedge clk) begin
		if (en.s4) begin
			rx_s4 <= round_sat(sum_x);
			ry_s4 <= round_sat(sum_y);
			rz_s4 <= round_sat(sum_z);
		end
	end

	assign rot_x = rx_s4;
	assign rot_y = ry_s4;
	assign rot_z = rz_s4;

endmodule

FILE: rtl/quaternion_vector_rotate.sv
`timescale 1ns / 1ps
// Data path: an accepted input transaction passes through s1, s2, s3 and s4 to m_tdata.
// Throughput: one rotation per cycle; the four-stage multiply pipeline takes a new
// transaction every cycle while the output side keeps up.
// Reset: arst_n clears the stage valid bits asynchronously; the datapath is not reset.
// ----------------------------------------------------------------------------
// quaternion_vector_rotate: rotate a 3-D vector by a quaternion
// Computes the vector part of q * (0, v) * conj(q) in signed fixed point,
// rounding each Hamilton product to nearest and saturating the result.
// ----------------------------------------------------------------------------
module quaternion_vector_rotate (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// Fields from bit 0 up: vec_x, vec_y, vec_z, quat_w, quat_i, quat_j, quat_k.
	input  logic [qvr_pkg::IN_TDATA_W-1:0]  s_tdata,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// Fields from bit 0 up: rot_x, rot_y, rot_z.
	output logic [qvr_pkg::OUT_TDATA_W-1:0] m_tdata
);
	import qvr_pkg::*;

	localparam int W = DATA_WIDTH;

	// The pipeline has four stages:
	//   s1  products of q and v
	//   s2  rounded components of t = q * (0, v)
	//   s3  products of t and conj(q)
	//   s4  rounded, saturated result (the output register)
	// Each stage has a valid bit. A stage loads whenever it is empty or the
	// stage after it is loading too, so bubbles close up and a stalled output
	// holds the whole chain without losing or repeating a transaction.

	stage_en_t en;
	logic      v_s1, v_s2, v_s3, v_s4;

	data_t vec_x, vec_y, vec_z, quat_w, quat_i, quat_j, quat_k;
	tq_t   t_w, t_x, t_y, t_z;
	data_t q_w, q_i, q_j, q_k;
	data_t rot_x, rot_y, rot_z;

	assign vec_x  = s_tdata[0*W +: W];
	assign vec_y  = s_tdata[1*W +: W];
	assign vec_z  = s_tdata[2*W +: W];
	assign quat_w = s_tdata[3*W +: W];
	assign quat_i = s_tdata[4*W +: W];
	assign quat_j = s_tdata[5*W +: W];
	assign quat_k = s_tdata[6*W +: W];

	// Ready ripples back from the output: a full stage can only move if the
	// stage ahead of it moves as well.
	always_comb begin
		en.s4 = !v_s4 || m_tready;
		en.s3 = !v_s3 || en.s4;
		en.s2 = !v_s2 || en.s3;
		en.s1 = !v_s1 || en.s2;
	end

	assign s_tready = en.s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en.s1) v_s1 <= s_tvalid;
			if (en.s2) v_s2 <= v_s1;
			if (en.s3) v_s3 <= v_s2;
			if (en.s4) v_s4 <= v_s3;
		end
	end

	qvr_qv_product u_qv (
		.clk    (clk),
		.en     (en),
		.vec_x  (vec_x),
		.vec_y  (vec_y),
		.vec_z  (vec_z),
		.quat_w (quat_w),
		.quat_i (quat_i),
		.quat_j (quat_j),
		.quat_k (quat_k),
		.t_w    (t_w),
		.t_x    (t_x),
		.t_y    (t_y),
		.t_z    (t_z),
		.q_w    (q_w),
		.q_i    (q_i),
		.q_j    (q_j),
		.q_k    (q_k)
	);

	qvr_conj_product u_conj (
		.clk   (clk),
		.en    (en),
		.t_w   (t_w),
		.t_x   (t_x),
		.t_y   (t_y),
		.t_z   (t_z),
		.q_w   (q_w),
		.q_i   (q_i),
		.q_j   (q_j),
		.q_k   (q_k),
		.rot_x (rot_x),
		.rot_y (rot_y),
		.rot_z (rot_z)
	);

	assign m_tvalid = v_s4;
	assign m_tdata  = OUT_TDATA_W'({rot_z, rot_y, rot_x});

	// The input side only stalls when every stage holds a transaction and the
	// output is not being taken.
	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (v_s1 && v_s2 && v_s3 && v_s4 && !m_tready))
		else $error("input stalled while the pipeline has room");

	// A transaction in stage 3 reaches the output register when the output moves.
	a_s3_advances: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && m_tready) |=> m_tvalid)
		else $error("stage 3 transaction lost on its way to the output");

	// An accepted transaction always lands in stage 1.
	a_accept_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> v_s1)
		else $error("accepted transaction not captured in stage 1");

	// Occupancy can only grow by one transaction per cycle.
	a_occupancy_step: assert property (@(posedge clk) disable iff (!arst_n)
		$countones({v_s1, v_s2, v_s3, v_s4})
			<= $countones($past({v_s1, v_s2, v_s3, v_s4})) + 1)
		else $error("pipeline occupancy grew by more than one");

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for quaternion_vector_rotate
// Streams vector and quaternion pairs through the rotator under varying
// source gaps and sink back-pressure. A directed table covers identity,
// zero, half-turn and saturating rotations; random transactions follow.
// Every result is checked against its hand-typed value or against a
// bit-accurate fixed point rotation computed here.
// ----------------------------------------------------------------------------
module tb;
	import qvr_pkg::*;

	localparam int RAND_PER_PHASE = 320;
	localparam int DIR_ROWS       = 20;
	localparam int DRAIN_CYCLES   = 20;
	localparam int CYCLE_LIMIT    = 200000;
	localparam int PRINT_LIMIT    = 40;

	// Packed so that vx lands in the lowest bits of tdata.
	typedef struct packed {
		data_t qk;
		data_t qj;
		data_t qi;
		data_t qw;
		data_t vz;
		data_t vy;
		data_t vx;
	} rot_in_t;

	typedef struct packed {
		data_t rz;
		data_t ry;
		data_t rx;
	} rot_out_t;

	// A result typed in by hand, or a request to compute it.
	typedef struct {
		bit       known;
		rot_out_t val;
	} expectation_t;

	typedef struct {
		rot_in_t      item;
		expectation_t tag;
	} dir_row_t;

	logic                   clk      = 1'b0;
	logic                   arst_n   = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata  = '0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;

	expectation_t known_q[$];
	rot_out_t     rotated_q[$];
	dir_row_t     directed_rows[DIR_ROWS];
	int           mismatch_count = 0;
	int           cycle_count    = 0;
	int           send_idle_pct  = 0;
	int           stall_pct      = 0;

	quaternion_vector_rotate uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Round to nearest with ties toward plus infinity, dropping FRAC bits.
	function automatic longint round_half_up(input longint sum);
		return (sum + (longint'(1) <<< (FRAC - 1))) >>> FRAC;
	endfunction

	function automatic data_t clamp_to_data(input longint v);
		longint hi;
		longint lo;
		hi = (longint'(1) <<< (DATA_WIDTH - 1)) - 1;
		lo = -(longint'(1) <<< (DATA_WIDTH - 1));
		if (v > hi) begin
			return data_t'(hi);
		end else if (v < lo) begin
			return data_t'(lo);
		end
		return data_t'(v);
	endfunction

	// Vector part of q * (0, v) * conj(q), each product sum rounded once.
	function automatic rot_out_t rotate_vector(input rot_in_t a);
		longint   vx, vy, vz, qw, qx, qy, qz;
		longint   t0, t1, t2, t3;
		rot_out_t r;
		vx = a.vx; vy = a.vy; vz = a.vz;
		qw = a.qw; qx = a.qi; qy = a.qj; qz = a.qk;
		t0 = round_half_up(-qx * vx - qy * vy - qz * vz);
		t1 = round_half_up(qw * vx + qy * vz - qz * vy);
		t2 = round_half_up(qw * vy - qx * vz + qz * vx);
		t3 = round_half_up(qw * vz + qx * vy - qy * vx);
		r.rx = clamp_to_data(round_half_up(-t0 * qx + t1 * qw - t2 * qz + t3 * qy));
		r.ry = clamp_to_data(round_half_up(-t0 * qy + t1 * qz + t2 * qw - t3 * qx));
		r.rz = clamp_to_data(round_half_up(-t0 * qz - t1 * qy + t2 * qx + t3 * qw));
		return r;
	endfunction

	function automatic dir_row_t make_row(input int vx, input int vy, input int vz,
			input int qw, input int qi, input int qj, input int qk,
			input bit known, input int rx, input int ry, input int rz);
		dir_row_t row;
		row.item.vx = data_t'(vx);
		row.item.vy = data_t'(vy);
		row.item.vz = data_t'(vz);
		row.item.qw = data_t'(qw);
		row.item.qi = data_t'(qi);
		row.item.qj = data_t'(qj);
		row.item.qk = data_t'(qk);
		row.tag.known  = known;
		row.tag.val.rx = data_t'(rx);
		row.tag.val.ry = data_t'(ry);
		row.tag.val.rz = data_t'(rz);
		return row;
	endfunction

	// Mix of full range values, values near unit magnitude, corner values
	// and tiny values, so that both saturating and exact rotations occur.
	function automatic data_t pick_component();
		int sel;
		sel = $urandom_range(99);
		if (sel < 25) begin
			return data_t'($urandom);
		end else if (sel < 70) begin
			return data_t'(int'($urandom_range(23170)) - 11585);
		end else if (sel < 88) begin
			case ($urandom_range(6))
				0: return data_t'(0);
				1: return data_t'(32767);
				2: return data_t'(-32768);
				3: return data_t'(16384);
				4: return data_t'(-16384);
				5: return data_t'(1);
				default: return data_t'(-1);
			endcase
		end
		return data_t'(int'($urandom_range(128)) - 64);
	endfunction

	task automatic flag_mismatch(input string msg);
		mismatch_count++;
		if (mismatch_count <= PRINT_LIMIT) begin
			$display("[%0t] mismatch: %s", $realtime, msg);
		end
	endtask

	task automatic check_field(input string name, input data_t got, input data_t want);
		if (got !== want) begin
			flag_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
		end
	endtask

	// Present one transaction and hold it until the rotator takes it.
	task automatic offer_rotation(input rot_in_t item, input expectation_t tag);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			s_tdata  <= IN_TDATA_W'({$urandom, $urandom, $urandom, $urandom});
			@(posedge clk);
		end
		known_q.push_back(tag);
		s_tvalid <= 1'b1;
		s_tdata  <= item;
		@(posedge clk);
		while (!s_tready) begin
			@(posedge clk);
		end
	endtask

	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= stall_pct);
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// Accepted inputs queue their expected rotation; accepted outputs are
	// compared with the oldest one.
	always @(posedge clk) begin : scoreboard
		expectation_t tag;
		rot_out_t     want;
		rot_out_t     got;
		if (s_tvalid && s_tready) begin
			tag = known_q.pop_front();
			want = tag.known ? tag.val : rotate_vector(rot_in_t'(s_tdata));
			rotated_q.push_back(want);
		end
		if (m_tvalid && m_tready) begin
			got = rot_out_t'(m_tdata);
			if (rotated_q.size() == 0) begin
				flag_mismatch($sformatf("unexpected result %h", m_tdata));
			end else begin
				want = rotated_q.pop_front();
				check_field("rot_x", got.rx, want.rx);
				check_field("rot_y", got.ry, want.ry);
				check_field("rot_z", got.rz, want.rz);
			end
		end
	end

	initial begin : stimulus
		expectation_t open_tag;
		rot_in_t      item;
		int           phase;

		// Zero quaternion, identity, half turns about each axis and saturation.
		directed_rows[0]  = make_row(0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0);
		directed_rows[1]  = make_row(32767, -32768, 12345, 0, 0, 0, 0, 1, 0, 0, 0);
		directed_rows[2]  = make_row(32767, -32768, 0, 16384, 0, 0, 0,
			1, 32767, -32768, 0);
		directed_rows[3]  = make_row(-1, 1, 16384, 16384, 0, 0, 0, 1, -1, 1, 16384);
		directed_rows[4]  = make_row(16384, -16384, 0, -32768, 0, 0, 0,
			1, 32767, -32768, 0);
		directed_rows[5]  = make_row(16384, 8192, -4096, 0, 0, 0, 16384,
			1, -16384, -8192, -4096);
		directed_rows[6]  = make_row(-32768, 0, 0, 0, 0, 0, 16384, 1, 32767, 0, 0);
		directed_rows[7]  = make_row(1, 2, 3, 0, 16384, 0, 0, 1, 1, -2, -3);
		directed_rows[8]  = make_row(100, -200, 300, 0, 0, 16384, 0,
			1, -100, -200, -300);
		directed_rows[9]  = make_row(32767, 32767, 32767, 16384, 0, 0, 0,
			1, 32767, 32767, 32767);
		// The rest are checked against the computed rotation.
		directed_rows[10] = make_row(-1, -1, -1, -1, -1, -1, -1, 0, 0, 0, 0);
		directed_rows[11] = make_row(32767, 32767, 32767, 32767, 32767, 32767, 32767,
			0, 0, 0, 0);
		directed_rows[12] = make_row(-32768, -32768, -32768, -32768, -32768, -32768,
			-32768, 0, 0, 0, 0);
		directed_rows[13] = make_row(32767, 32767, 32767, -32768, -32768, -32768,
			-32768, 0, 0, 0, 0);
		directed_rows[14] = make_row(21845, -21846, 21845, -21846, 21845, -21846,
			21845, 0, 0, 0, 0);
		directed_rows[15] = make_row(-21846, 21845, -21846, 21845, -21846, 21845,
			-21846, 0, 0, 0, 0);
		directed_rows[16] = make_row(16384, 0, 0, 11585, 0, 0, 11585, 0, 0, 0, 0);
		directed_rows[17] = make_row(0, 16384, -16384, 11585, 11585, 0, 0, 0, 0, 0, 0);
		directed_rows[18] = make_row(1000, -2000, 3000, 8192, 8192, 8192, 8192,
			0, 0, 0, 0);
		directed_rows[19] = make_row(32767, -32768, 1, 1, 1, 1, 1, 0, 0, 0, 0);

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		open_tag.known = 1'b0;
		open_tag.val   = '0;
		for (phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin send_idle_pct = 0;  stall_pct = 0;  end
				1: begin send_idle_pct = 70; stall_pct = 0;  end
				2: begin send_idle_pct = 0;  stall_pct = 70; end
				default: begin send_idle_pct = 34; stall_pct = 34; end
			endcase
			if (phase == 0) begin
				for (int n = 0; n < DIR_ROWS; n++) begin
					offer_rotation(directed_rows[n].item, directed_rows[n].tag);
				end
			end
			repeat (RAND_PER_PHASE) begin
				item.vx = pick_component();
				item.vy = pick_component();
				item.vz = pick_component();
				item.qw = pick_component();
				item.qi = pick_component();
				item.qj = pick_component();
				item.qk = pick_component();
				offer_rotation(item, open_tag);
			end
		end
		s_tvalid <= 1'b0;

		while (known_q.size() != 0 || rotated_q.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatch_count == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
